>>> sv/evg_pkg.sv
package evg_pkg;

    localparam int MAX_POINTS = 1024;

    // register map of the configuration channel
    typedef enum logic [2:0] {
        REG_SIZE_X = 3'd0,
        REG_SIZE_Y = 3'd1,
        REG_THICK  = 3'd2,
        REG_POINTS = 3'd3,
        REG_MODE   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] size_x;
        logic [15:0] size_y;
        logic [15:0] thickness;
        logic [10:0] n;          // clamped point count, 1..MAX_POINTS
        logic        outline;
    } t_cfg;

    // one classified vertex request
    typedef struct packed {
        logic        valid_res;
        logic        last;
        logic        centre;
        logic        inner;
        logic [10:0] k;
    } t_job;

    // job queue between front and back, depth is a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int LAT_DIV    = 17;
    localparam int LAT_TRIG   = 17;
    localparam int JOB_STAGES = LAT_DIV + LAT_TRIG + 1;

    localparam logic [30:0] PI_Q29  = 31'd1686629713;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    // series terms, row 0 sine, row 1 cosine, innermost term first
    localparam int TERMS = 4;
    localparam logic [6:0] TERM_DIV [2][TERMS] = '{
        '{7'd72, 7'd42, 7'd20, 7'd6},
        '{7'd56, 7'd30, 7'd12, 7'd2}
    };
    localparam logic [31:0] TERM_MAG [2][TERMS] = '{
        '{32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
          32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)},
        '{32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
          32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)}
    };

endpackage

>>> sv/evg_front.sv
module evg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_push,
    input  logic [11:0]   i_vertex_index,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output evg_pkg::t_job o_job,
    output evg_pkg::t_cfg o_cfg
);
    import evg_pkg::*;

    logic [15:0] r_size_x;
    logic [15:0] r_size_y;
    logic [15:0] r_thick;
    logic [10:0] r_points;
    logic        r_mode;

    logic [10:0] n;
    logic [11:0] count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= '0;
            r_size_y <= '0;
            r_thick  <= '0;
            r_points <= 11'd32;
            r_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SIZE_X: r_size_x <= i_cfg_data;
                REG_SIZE_Y: r_size_y <= i_cfg_data;
                REG_THICK:  r_thick  <= i_cfg_data;
                REG_POINTS: r_points <= i_cfg_data[10:0];
                REG_MODE:   r_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_points == 11'd0) begin
            n = 11'd1;
        end else if (r_points > 11'(MAX_POINTS)) begin
            n = 11'(MAX_POINTS);
        end else begin
            n = r_points;
        end
        count = r_mode ? ({n, 1'b0} + 12'd2) : ({1'b0, n} + 12'd2);
    end

    assign o_cfg = '{size_x: r_size_x, size_y: r_size_y, thickness: r_thick,
                     n: n, outline: r_mode};

    always_comb begin
        o_job.valid_res = i_vertex_index < count;
        o_job.last      = o_job.valid_res && (i_vertex_index == count - 12'd1);
        o_job.centre    = 1'b0;
        o_job.inner     = 1'b0;
        o_job.k         = '0;
        if (!o_job.valid_res) begin
            o_job.centre = 1'b1;
        end else if (r_mode) begin
            o_job.inner = i_vertex_index[0];
            o_job.k     = i_vertex_index[11:1];
        end else if (i_vertex_index == 12'd0) begin
            o_job.centre = 1'b1;
        end else begin
            o_job.k = 11'(i_vertex_index - 12'd1);
        end
    end

    assign o_q_wr = i_push && !i_q_full;

endmodule

>>> sv/evg_fifo.sv
module evg_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  evg_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_rd,
    output evg_pkg::t_job o_data,
    output logic          o_empty
);
    import evg_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_empty = r_cnt == '0;

endmodule

>>> sv/evg_div.sv
module evg_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [10:0] i_k,
    input  logic [10:0] i_n,
    output logic [15:0] o_quo
);
    import evg_pkg::*;

    // round(k * 65536 / n): restoring division, one quotient bit per stage
    logic [26:0] dvd;
    logic [9:0]  r_rem  [LAT_DIV];
    logic [16:0] r_bits [LAT_DIV];
    logic [15:0] r_quo  [LAT_DIV];

    assign dvd = {i_k, 16'd0} + 27'(i_n >> 1);

    for (genvar s = 0; s < LAT_DIV; s++) begin : g_step
        logic [9:0]  rem_in;
        logic [16:0] bits_in;
        logic [15:0] quo_in;
        logic [10:0] trial;
        logic        ge;

        if (s == 0) begin : g_first
            assign rem_in  = dvd[26:17];
            assign bits_in = dvd[16:0];
            assign quo_in  = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign bits_in = r_bits[s-1];
            assign quo_in  = r_quo[s-1];
        end

        assign trial = {rem_in, bits_in[LAT_DIV-1-s]};
        assign ge    = trial >= i_n;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? 10'(trial - i_n) : trial[9:0];
                r_bits[s] <= bits_in;
                r_quo[s]  <= {quo_in[14:0], ge};
            end
        end
    end

    assign o_quo = r_quo[LAT_DIV-1];

endmodule

>>> sv/evg_trig.sv
module evg_trig (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_ang,
    output logic signed [16:0] o_co,
    output logic signed [16:0] o_si
);
    import evg_pkg::*;

    typedef struct packed {
        logic [29:0] x;
        logic [29:0] x2;
        logic [1:0]  quad;
        logic        swap;
    } t_side;

    localparam int SIDE_N = 3 + 3 * TERMS + 1;

    t_side       r_sd [SIDE_N];
    logic [13:0] r_g;
    logic [30:0] r_p  [2][TERMS];
    logic [30:0] r_pb [2][TERMS];
    logic [30:0] r_qe [2][TERMS];
    logic [30:0] r_t  [2][TERMS];
    logic [30:0] r_s;
    logic [30:0] r_c;

    logic [13:0] f;
    logic        swap0;
    logic [44:0] xp;
    logic [59:0] xx;
    logic [60:0] sp;

    function automatic logic [16:0] to_q15(input logic [30:0] v);
        logic [31:0] sum;
        sum = {1'b0, v} + 32'd16384;
        return (sum[31:15] > 17'd32768) ? 17'd32768 : sum[31:15];
    endfunction

    // fold the angle into the first octant
    assign f     = i_ang[13:0];
    assign swap0 = f > 14'd8192;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g             <= swap0 ? 14'(15'd16384 - {1'b0, f}) : f;
            r_sd[0].x       <= '0;
            r_sd[0].x2      <= '0;
            r_sd[0].quad    <= i_ang[15:14];
            r_sd[0].swap    <= swap0;
        end
    end

    assign xp = r_g * PI_Q29;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[1] <= '{x: xp[43:14], x2: r_sd[0].x2, quad: r_sd[0].quad,
                         swap: r_sd[0].swap};
        end
    end

    assign xx = r_sd[1].x * r_sd[1].x;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[2] <= '{x: r_sd[1].x, x2: xx[59:30], quad: r_sd[1].quad,
                         swap: r_sd[1].swap};
        end
    end

    for (genvar s = 3; s < SIDE_N; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[s] <= r_sd[s-1];
            end
        end
    end

    // Horner steps: t = 1 - (x2 * t) / d, with d by reciprocal and one correction
    for (genvar c = 0; c < 2; c++) begin : g_chain
        for (genvar j = 0; j < TERMS; j++) begin : g_term
            logic [30:0] t_in;
            logic [60:0] pt;
            logic [62:0] m;
            logic [37:0] qd;
            logic [30:0] rr;
            logic [30:0] q;

            if (j == 0) begin : g_head
                assign t_in = ONE_Q30;
            end else begin : g_tail
                assign t_in = r_t[c][j-1];
            end

            assign pt = r_sd[2+3*j].x2 * t_in;
            assign m  = r_p[c][j] * TERM_MAG[c][j];
            assign qd = r_qe[c][j] * TERM_DIV[c][j];
            assign rr = r_pb[c][j] - qd[30:0];
            assign q  = (rr >= 31'(TERM_DIV[c][j])) ? r_qe[c][j] + 31'd1 : r_qe[c][j];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p[c][j]  <= pt[60:30];
                    r_qe[c][j] <= m[62:32];
                    r_pb[c][j] <= r_p[c][j];
                    r_t[c][j]  <= ONE_Q30 - q;
                end
            end
        end
    end

    assign sp = r_sd[SIDE_N-2].x * r_t[0][TERMS-1];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= sp[60:30];
            r_c <= r_t[1][TERMS-1];
        end
    end

    // round to Q1.15, undo the octant fold, map to the quadrant
    always_ff @(posedge i_clk) begin
        logic signed [16:0] sv;
        logic signed [16:0] cv;
        if (i_en) begin
            sv = $signed(r_sd[SIDE_N-1].swap ? to_q15(r_c) : to_q15(r_s));
            cv = $signed(r_sd[SIDE_N-1].swap ? to_q15(r_s) : to_q15(r_c));
            case (r_sd[SIDE_N-1].quad)
                2'd0: begin
                    o_co <= cv;
                    o_si <= sv;
                end
                2'd1: begin
                    o_co <= -sv;
                    o_si <= cv;
                end
                2'd2: begin
                    o_co <= -cv;
                    o_si <= -sv;
                end
                default: begin
                    o_co <= sv;
                    o_si <= -cv;
                end
            endcase
        end
    end

endmodule

>>> sv/evg_back.sv
module evg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  evg_pkg::t_cfg      i_cfg,
    input  logic               i_q_empty,
    input  evg_pkg::t_job      i_q_job,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [17:0] o_pos_x,
    output logic signed [17:0] o_pos_y,
    output logic               o_valid_res,
    output logic               o_last
);
    import evg_pkg::*;

    localparam int TRIG_AT = LAT_DIV + LAT_TRIG - 1;

    logic                  en;
    logic [JOB_STAGES-1:0] r_jv;
    t_job                  r_job [JOB_STAGES];
    logic [15:0]           ang;
    logic signed [16:0]    co;
    logic signed [16:0]    si;
    logic signed [17:0]    rad_x;
    logic signed [17:0]    rad_y;
    logic signed [16:0]    tx;
    logic signed [16:0]    ty;
    logic signed [34:0]    r_px;
    logic signed [34:0]    r_py;
    logic signed [35:0]    num_x;
    logic signed [35:0]    num_y;
    logic                  r_out_valid;

    // the whole pipeline moves when the result register is free or being taken
    assign en     = !r_out_valid || i_pop;
    assign o_q_rd = en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jv <= '0;
        end else if (en) begin
            r_jv <= {r_jv[JOB_STAGES-2:0], o_q_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job[0] <= i_q_job;
            for (int s = 1; s < JOB_STAGES; s++) begin
                r_job[s] <= r_job[s-1];
            end
        end
    end

    evg_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_k   (i_q_job.k),
        .i_n   (i_cfg.n),
        .o_quo (ang)
    );

    evg_trig u_trig (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (ang),
        .o_co  (co),
        .o_si  (si)
    );

    always_comb begin
        rad_x = $signed({2'b00, i_cfg.size_x});
        rad_y = $signed({2'b00, i_cfg.size_y});
        if (r_job[TRIG_AT].inner) begin
            rad_x = rad_x - $signed({1'b0, i_cfg.thickness, 1'b0});
            rad_y = rad_y - $signed({1'b0, i_cfg.thickness, 1'b0});
        end
        tx = r_job[TRIG_AT].centre ? 17'sd0 : co;
        ty = r_job[TRIG_AT].centre ? 17'sd0 : si;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= rad_x * tx;
            r_py <= rad_y * ty;
        end
    end

    assign num_x = $signed({5'd0, i_cfg.size_x, 15'd0}) + 36'(r_px) + 36'sd32768;
    assign num_y = $signed({5'd0, i_cfg.size_y, 15'd0}) + 36'(r_py) + 36'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_jv[JOB_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_job[JOB_STAGES-1].valid_res) begin
                o_pos_x <= num_x[33:16];
                o_pos_y <= num_y[33:16];
            end else begin
                o_pos_x <= '0;
                o_pos_y <= '0;
            end
            o_valid_res <= r_job[JOB_STAGES-1].valid_res;
            o_last      <= r_job[JOB_STAGES-1].last;
        end
    end

    assign o_empty = !r_out_valid;

endmodule

>>> sv/ellipse_vertex_generator_core.sv
// Channel   Direction  Handshake               Word
// -------   ---------  ----------------------  -----------------------------------------
// request   in         push / full             i_vertex_index
// result    out        empty / pop             o_pos_x, o_pos_y, o_valid_res, o_last
// config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One word per cycle in and out when neither side stalls. A request is written to the
// job queue at the push edge and leaves it when the back pipeline moves, entering the
// first of 17 quotient stages for the angle, then 17 sine/cosine series stages and two
// to place and register the position. Reset is synchronous, active low, and empties the
// queue and pipeline. Holding pop low while a result waits freezes the back pipeline;
// the four-word job queue keeps taking requests until it fills, then full rises.
module ellipse_vertex_generator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [11:0]        i_vertex_index,
    output logic               empty,
    input  logic               pop,
    output logic signed [17:0] o_pos_x,
    output logic signed [17:0] o_pos_y,
    output logic               o_valid_res,
    output logic               o_last
);
    import evg_pkg::*;

    t_cfg cfg;
    t_job wr_job;
    t_job rd_job;
    logic q_wr;
    logic q_rd;
    logic q_empty;

    // front: hold configuration, classify each index into a job
    evg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_vertex_index (i_vertex_index),
        .i_q_full       (full),
        .o_q_wr         (q_wr),
        .o_job          (wr_job),
        .o_cfg          (cfg)
    );

    // short job queue decouples request side from the result side
    evg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (wr_job),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_data  (rd_job),
        .o_empty (q_empty)
    );

    // back: angle, trig, position; the last stage is the result register
    evg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_q_job     (rd_job),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_valid_res (o_valid_res),
        .o_last      (o_last)
    );

endmodule

>>> sv/evg_checker.sv
module evg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [17:0] o_pos_x,
    input logic signed [17:0] o_pos_y,
    input logic               o_valid_res,
    input logic               o_last
);

    // reset drains the result side
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // an index past the end carries zero positions and no last flag
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_valid_res) |-> (o_pos_x == 18'sd0 && o_pos_y == 18'sd0 && !o_last))
        else $error("invalid vertex with nonzero fields");

    // last vertex is always a valid one
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> o_valid_res)
        else $error("last set on invalid vertex");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pos_x) && $stable(o_pos_y)))
        else $error("stalled result changed");

endmodule

bind ellipse_vertex_generator_core evg_checker u_evg_checker (.*);
